@@ rtl/core/quadrature_decoder_x4_glitch_gate_defines.svh @@
// Assertion macros used by the quadrature decoder top level.
`ifndef QUADRATURE_DECODER_X4_GLITCH_GATE_DEFINES_SVH
`define QUADRATURE_DECODER_X4_GLITCH_GATE_DEFINES_SVH

`ifndef ASSERT_OFF

`define QDX4_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define QDX4_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define QDX4_ASSERT(label, clk, rst_n, prop)
`define QDX4_ASSERT_NR(label, clk, prop)

`endif

`endif

@@ rtl/core/qdx4_pkg.sv @@
// Types, register indexes and the Gray transition table of the quadrature decoder.
package qdx4_pkg;

  localparam int unsigned CFG_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_A_SEL   = 2'd0,
    REG_B_SEL   = 2'd1,
    REG_MIN_GAP = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    OUTC_NONE    = 3'd0,
    OUTC_STEP    = 3'd1,
    OUTC_INVALID = 3'd2,
    OUTC_GLITCH  = 3'd3,
    OUTC_RESYNC  = 3'd4
  } outcome_t;

  localparam logic [1:0] STEP_ZERO = 2'b00;
  localparam logic [1:0] STEP_UP   = 2'b01;
  localparam logic [1:0] STEP_DOWN = 2'b11;

  typedef struct packed {
    logic [2:0]  a_sel;
    logic [2:0]  b_sel;
    logic [15:0] min_gap;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  port_byte;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [31:0] position;
    logic [15:0] invalid_cnt;
    logic [15:0] rejected_cnt;
    logic [31:0] last_ms;
  } state_t;

  // Step for a transition, indexed by the old phase then the new phase.
  function automatic logic [1:0] gray_step(input logic [1:0] prev, input logic [1:0] phase);
    logic [1:0] d;
    case ({prev, phase})
      4'd2, 4'd4, 4'd11, 4'd13: d = STEP_UP;
      4'd1, 4'd7, 4'd8, 4'd14:  d = STEP_DOWN;
      default:                  d = STEP_ZERO;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/core/qdx4_cfg.sv @@
// APB-style configuration registers of the quadrature decoder.
module qdx4_cfg
  import qdx4_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_A_SEL:   cfg_nxt.a_sel   = cfg_pwdata[2:0];
        REG_B_SEL:   cfg_nxt.b_sel   = cfg_pwdata[2:0];
        REG_MIN_GAP: cfg_nxt.min_gap = cfg_pwdata[15:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_A_SEL:   cfg_prdata = {29'b0, cfg_r.a_sel};
      REG_B_SEL:   cfg_prdata = {29'b0, cfg_r.b_sel};
      REG_MIN_GAP: cfg_prdata = {16'b0, cfg_r.min_gap};
      default:     cfg_prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.a_sel   <= 3'd0;
      cfg_r.b_sel   <= 3'd1;
      cfg_r.min_gap <= 16'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/core/qdx4_step.sv @@
// Decode logic for one sample: resync command, phase pick, glitch gate, Gray step and counters.
module qdx4_step
  import qdx4_pkg::*;
(
  input  cfg_t       cfg,
  input  item_t      item,
  input  state_t     st,
  output state_t     st_nxt,
  output logic [1:0] step,
  output outcome_t   outcome
);

  logic [1:0]  phase;
  logic [31:0] elapsed;
  logic        too_soon;
  logic [1:0]  d;

  assign phase    = {item.port_byte[cfg.a_sel], item.port_byte[cfg.b_sel]};
  assign elapsed  = item.now_ms - st.last_ms;
  assign too_soon = (cfg.min_gap != 16'd0) && (elapsed < {16'b0, cfg.min_gap});
  assign d        = gray_step(st.phase, phase);

  always_comb begin
    st_nxt  = st;
    step    = STEP_ZERO;
    outcome = OUTC_NONE;
    if (item.cmd) begin
      st_nxt.phase        = phase;
      st_nxt.position     = 32'd0;
      st_nxt.invalid_cnt  = 16'd0;
      st_nxt.rejected_cnt = 16'd0;
      st_nxt.last_ms      = item.now_ms;
      outcome             = OUTC_RESYNC;
    end else if (phase != st.phase) begin
      if (too_soon) begin
        st_nxt.rejected_cnt = st.rejected_cnt + 16'd1;
        outcome             = OUTC_GLITCH;
      end else begin
        if (cfg.min_gap != 16'd0) begin
          st_nxt.last_ms = item.now_ms;
        end
        st_nxt.phase = phase;
        if (d == STEP_ZERO) begin
          st_nxt.invalid_cnt = st.invalid_cnt + 16'd1;
          outcome            = OUTC_INVALID;
        end else begin
          step            = d;
          st_nxt.position = st.position + {{30{d[1]}}, d};
          outcome         = OUTC_STEP;
        end
      end
    end
  end

endmodule

@@ rtl/core/quadrature_decoder_x4_glitch_gate.sv @@
// Top level of the x4 quadrature decoder with an edge-interval glitch gate.
// A result is registered in the output register after its item passes the input register.
// Throughput: one transaction per cycle while out_tready is high; the input register and
// the decode logic both sit before the result register, so back-to-back items stream without gaps.
// Reset is synchronous and active low; it clears phase, position, both counters,
// the last edge time and the configuration registers to their reset values.
`include "quadrature_decoder_x4_glitch_gate_defines.svh"

module quadrature_decoder_x4_glitch_gate
  import qdx4_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [39:0]           in_tdata,  // port_byte[7:0], now_ms[39:8]
  input  logic                  in_tuser,  // cmd[0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // position[31:0], invalid_cnt[47:32], rejected_cnt[63:48], step[65:64], zeros[71:66]
  output logic [71:0]           out_tdata,
  output logic [2:0]            out_tuser, // outcome[2:0]
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t       cfg;
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  item_t      s1_item_r;
  state_t     st_r;
  state_t     st_nxt;
  logic [1:0] step;
  outcome_t   outcome;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [71:0] out_data_r;
  outcome_t   out_outcome_r;
  logic       out_free;
  logic       adv;
  logic       in_acc;

  qdx4_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  qdx4_step u_step (
    .cfg     (cfg),
    .item    (s1_item_r),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .step    (step),
    .outcome (outcome)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && !out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_outcome_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.cmd       <= in_tuser;
      s1_item_r.port_byte <= in_tdata[7:0];
      s1_item_r.now_ms    <= in_tdata[39:8];
    end
    if (adv) begin
      out_data_r    <= {6'b0, step, st_nxt.rejected_cnt, st_nxt.invalid_cnt, st_nxt.position};
      out_outcome_r <= outcome;
    end
  end

  `QDX4_ASSERT(a_step_matches_outcome, clk, rst_n,
    out_valid_r |-> ((out_data_r[65:64] != STEP_ZERO) == (out_outcome_r == OUTC_STEP)))
  `QDX4_ASSERT(a_resync_clears, clk, rst_n,
    (out_valid_r && out_outcome_r == OUTC_RESYNC) |-> (out_data_r[63:0] == 64'd0))
  `QDX4_ASSERT(a_state_holds_when_idle, clk, rst_n, !adv |=> $stable(st_r))
  `QDX4_ASSERT(a_result_matches_state, clk, rst_n,
    $past(adv) |-> (out_data_r[31:0] == st_r.position))
  `QDX4_ASSERT_NR(a_reset_empties_pipe, clk, !rst_n |=> (!s1_valid_r && !out_valid_r))

endmodule

@@ tb/quadrature_decoder_x4_glitch_gate_tb.sv @@
// Self-checking testbench for the x4 quadrature decoder: directed table, then random phases.
module quadrature_decoder_x4_glitch_gate_tb;
  import qdx4_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int HOLD_CYCLES     = 80;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 150;

  // Step code per transition, indexed by {old phase, new phase}.
  localparam logic [31:0] MOVE_TABLE = {
    STEP_ZERO, STEP_DOWN, STEP_UP,   STEP_ZERO,
    STEP_UP,   STEP_ZERO, STEP_ZERO, STEP_DOWN,
    STEP_DOWN, STEP_ZERO, STEP_ZERO, STEP_UP,
    STEP_ZERO, STEP_UP,   STEP_DOWN, STEP_ZERO
  };

  typedef struct packed {
    logic [31:0] position;
    logic [15:0] inv_count;
    logic [15:0] rej_count;
    logic [1:0]  step;
    outcome_t    outcome;
  } result_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic [31:0] value;
    logic        cmd;
    logic [7:0]  port;
    logic [31:0] now;
    logic        typed;
    result_t     want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [39:0]           in_tdata;  // port_byte[7:0], now_ms[39:8]
  logic                  in_tuser;  // cmd[0]
  logic                  out_tvalid;
  logic                  out_tready;
  // position[31:0], invalid_cnt[47:32], rejected_cnt[63:48], step[65:64], zeros[71:66]
  logic [71:0]           out_tdata;
  logic [2:0]            out_tuser; // outcome[2:0]
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  logic [2:0]  dec_a_sel;
  logic [2:0]  dec_b_sel;
  logic [15:0] dec_min_gap;
  logic [1:0]  dec_phase;
  logic [31:0] dec_position;
  logic [15:0] dec_invalid;
  logic [15:0] dec_rejected;
  logic [31:0] dec_last_ms;

  result_t expected_results[$];
  row_t    rows[$];
  int      mismatches;
  logic    offer_typed;
  result_t offer_want;
  logic    steady;
  logic    hold_request;
  int      stall_left;

  quadrature_decoder_x4_glitch_gate DUT (.*);

  always #10 clk = ~clk;

  function automatic result_t decode_sample(input logic cmd, input logic [7:0] port,
                                            input logic [31:0] now);
    result_t    r;
    logic [1:0] ph;
    logic [1:0] mv;
    logic       pass;
    ph = {port[dec_a_sel], port[dec_b_sel]};
    r.step = STEP_ZERO;
    r.outcome = OUTC_NONE;
    if (cmd) begin
      dec_position = '0;
      dec_invalid = '0;
      dec_rejected = '0;
      dec_last_ms = now;
      dec_phase = ph;
      r.outcome = OUTC_RESYNC;
    end else if (ph != dec_phase) begin
      pass = 1'b1;
      if (dec_min_gap != 16'd0) begin
        if (now - dec_last_ms < {16'd0, dec_min_gap}) begin
          dec_rejected = dec_rejected + 16'd1;
          r.outcome = OUTC_GLITCH;
          pass = 1'b0;
        end else begin
          dec_last_ms = now;
        end
      end
      if (pass) begin
        mv = MOVE_TABLE[{dec_phase, ph, 1'b0} +: 2];
        if (mv == STEP_ZERO) begin
          dec_invalid = dec_invalid + 16'd1;
          r.outcome = OUTC_INVALID;
        end else begin
          r.step = mv;
          dec_position = dec_position + {{30{mv[1]}}, mv};
          r.outcome = OUTC_STEP;
        end
        dec_phase = ph;
      end
    end
    r.position = dec_position;
    r.inv_count = dec_invalid;
    r.rej_count = dec_rejected;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input result_t got, input result_t want);
    if (got.position !== want.position)
      report_mismatch("position", got.position, want.position);
    if (got.inv_count !== want.inv_count)
      report_mismatch("invalid count", 32'(got.inv_count), 32'(want.inv_count));
    if (got.rej_count !== want.rej_count)
      report_mismatch("rejected count", 32'(got.rej_count), 32'(want.rej_count));
    if (got.step !== want.step)
      report_mismatch("step", 32'(got.step), 32'(want.step));
    if (got.outcome !== want.outcome)
      report_mismatch("outcome", 32'(got.outcome), 32'(want.outcome));
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.position = out_tdata[31:0];
        got.inv_count = out_tdata[47:32];
        got.rej_count = out_tdata[63:48];
        got.step = out_tdata[65:64];
        got.outcome = outcome_t'(out_tuser);
        if (expected_results.size() == 0)
          report_mismatch("result with no transaction pending", got.position, '0);
        else
          check_result(got, expected_results.pop_front());
      end
      if (in_tvalid && in_tready) begin
        want = decode_sample(in_tuser, in_tdata[7:0], in_tdata[39:8]);
        expected_results.push_back(offer_typed ? offer_want : want);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_item(input logic cmd, input logic [7:0] port, input logic [31:0] now);
    row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.cmd = cmd;
    row.port = port;
    row.now = now;
    rows.push_back(row);
  endtask

  task automatic add_typed(input logic cmd, input logic [7:0] port, input logic [31:0] now,
                           input logic [31:0] pos, input logic [15:0] err,
                           input logic [15:0] gl, input logic [1:0] stp, input outcome_t outc);
    row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.cmd = cmd;
    row.port = port;
    row.now = now;
    row.typed = 1'b1;
    row.want.position = pos;
    row.want.inv_count = err;
    row.want.rej_count = gl;
    row.want.step = stp;
    row.want.outcome = outc;
    rows.push_back(row);
  endtask

  task automatic add_write(input reg_idx_t idx, input logic [31:0] value);
    row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.idx = idx;
    row.value = value;
    rows.push_back(row);
  endtask

  task automatic offer_item(input logic cmd, input logic [7:0] port, input logic [31:0] now,
                            input logic typed, input result_t want);
    int gap;
    offer_typed = typed;
    offer_want = want;
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {now, port};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== value)
      report_mismatch("register read back", cfg_prdata, value);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_A_SEL:   dec_a_sel = value[2:0];
      REG_B_SEL:   dec_b_sel = value[2:0];
      REG_MIN_GAP: dec_min_gap = value[15:0];
      default: ;
    endcase
  endtask

  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!steady) stall_left = pick_gap();
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
        quiet = 0;
      else
        quiet++;
    end
    $display("quadrature_decoder_x4_glitch_gate_tb NOT OK");
    $finish;
  end

  initial begin
    row_t        row;
    result_t     none;
    logic        cmd;
    logic [7:0]  port;
    logic [1:0]  target;
    logic [31:0] now_tick;
    logic [2:0]  a_sel;
    logic [2:0]  b_sel;
    logic [15:0] gap;
    int          r;
    none = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatches = 0;
    offer_typed = 1'b0;
    offer_want = '0;
    steady = 1'b0;
    hold_request = 1'b0;
    dec_a_sel = 3'd0;
    dec_b_sel = 3'd1;
    dec_min_gap = '0;
    dec_phase = '0;
    dec_position = '0;
    dec_invalid = '0;
    dec_rejected = '0;
    dec_last_ms = '0;
    now_tick = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Steps from the reset phase, then extremes of the port byte and the tick.
    add_typed(1'b0, 8'h00, 32'd0, 32'd0, 16'd0, 16'd0, STEP_ZERO, OUTC_NONE);
    add_typed(1'b0, 8'h01, 32'd1, 32'd1, 16'd0, 16'd0, STEP_UP, OUTC_STEP);
    add_item(1'b0, 8'h03, 32'd2);
    add_item(1'b0, 8'h02, 32'd3);
    add_item(1'b0, 8'h00, 32'd4);
    add_item(1'b0, 8'h02, 32'd5);
    add_item(1'b0, 8'hFD, 32'd6);
    add_item(1'b0, 8'hFF, 32'hFFFF_FFFF);
    add_item(1'b0, 8'h00, 32'd7);
    // With the gate off an invalid jump leaves the edge time alone.
    add_typed(1'b1, 8'h00, 32'd1000, 32'd0, 16'd0, 16'd0, STEP_ZERO, OUTC_RESYNC);
    add_typed(1'b0, 8'h03, 32'd1001, 32'd0, 16'd1, 16'd0, STEP_ZERO, OUTC_INVALID);
    add_write(REG_MIN_GAP, 32'd10);
    add_item(1'b0, 8'h01, 32'd1005);
    add_item(1'b0, 8'h01, 32'd1010);
    add_item(1'b0, 8'h02, 32'd1012);
    // An invalid jump through the gate still moves the edge time.
    add_item(1'b0, 8'h02, 32'd1030);
    add_item(1'b0, 8'h00, 32'd1035);
    // A tick that runs backward reads as a long elapsed time.
    add_item(1'b0, 8'h01, 32'd3);
    // Both channels on bit 7 with the widest gate.
    add_write(REG_MIN_GAP, 32'd65535);
    add_write(REG_A_SEL, 32'd7);
    add_write(REG_B_SEL, 32'd7);
    add_typed(1'b1, 8'h00, 32'hFFFF_FFFF, 32'd0, 16'd0, 16'd0, STEP_ZERO, OUTC_RESYNC);
    add_typed(1'b0, 8'h80, 32'hFFFF_FFFF, 32'd0, 16'd0, 16'd1, STEP_ZERO, OUTC_GLITCH);
    add_typed(1'b0, 8'h80, 32'h0000_FFFE, 32'd0, 16'd1, 16'd1, STEP_ZERO, OUTC_INVALID);
    add_item(1'b0, 8'h7F, 32'h0001_0000);

    foreach (rows[i]) begin
      row = rows[i];
      if (row.kind == ROW_WRITE) begin
        wait_drained();
        write_reg(row.idx, row.value);
      end else begin
        offer_item(row.cmd, row.port, row.now, row.typed, row.want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin a_sel = 3'd0; b_sel = 3'd1; gap = 16'd0; end
        1: begin a_sel = 3'd7; b_sel = 3'd0; gap = 16'd65535; end
        2: begin a_sel = 3'd3; b_sel = 3'd3; gap = 16'd5; end
        3: begin a_sel = 3'd5; b_sel = 3'd2; gap = 16'd1; end
        default: begin
          a_sel = 3'($urandom_range(0, 7));
          b_sel = 3'($urandom_range(0, 7));
          gap = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 40));
        end
      endcase
      write_reg(REG_A_SEL, {29'd0, a_sel});
      write_reg(REG_B_SEL, {29'd0, b_sel});
      write_reg(REG_MIN_GAP, {16'd0, gap});
      steady = (p == 5);
      if (p == 3) hold_request = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(0, 99);
        cmd = 1'b0;
        port = 8'($urandom_range(0, 255));
        if (r < 5) begin
          cmd = 1'b1;
        end else if (r >= 13) begin
          if (r < 23) target = dec_phase;
          else if (r < 33) target = ~dec_phase;
          else if (r < 66) target = {~dec_phase[0], dec_phase[1]};
          else target = {dec_phase[0], ~dec_phase[1]};
          port[dec_a_sel] = target[1];
          port[dec_b_sel] = target[0];
        end
        if ($urandom_range(0, 19) == 0)
          now_tick = $urandom();
        else
          now_tick = now_tick + $urandom_range(0, 2 * dec_min_gap + 3);
        offer_item(cmd, port, now_tick, 1'b0, none);
      end
    end

    steady = 1'b0;
    wait_drained();
    if (mismatches == 0)
      $display("quadrature_decoder_x4_glitch_gate_tb OK");
    else
      $display("quadrature_decoder_x4_glitch_gate_tb NOT OK");
    $finish;
  end

endmodule
